@@ rtl/box_filter_boundary_modes_defines.svh @@
// ----------------------------------------------------------------------------
// box filter assertion macros
// shared concurrent assertion forms, clocked on clk, reset by arst_n
// ----------------------------------------------------------------------------
`ifndef BOX_FILTER_BOUNDARY_MODES_DEFINES_SVH
`define BOX_FILTER_BOUNDARY_MODES_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define BFBM_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// expression never true
`define BFBM_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

@@ rtl/bfbm_pkg.sv @@
// ----------------------------------------------------------------------------
// bfbm_pkg
// shared types and constants of the box mean filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package bfbm_pkg;
	localparam int MAX_ROWS   = 256;
	localparam int MAX_COLS   = 256;
	localparam int MAX_WINDOW = 31;
	localparam int DIM_W      = 9;
	localparam int IDX_W      = 8;
	localparam int POS_W      = 16;
	localparam int SUM_W      = 18;
	localparam int CNT_W      = 10;
	localparam int DVD_W      = SUM_W + 8;
	localparam int DIV_CNT_W  = 5;

	typedef enum logic [1:0] {
		BM_SYMMETRIC = 2'd0,
		BM_REPLICATE = 2'd1,
		BM_CIRCULAR  = 2'd2,
		BM_ZERO_PAD  = 2'd3
	} bfbm_mode_t;

	typedef enum logic [1:0] {
		REG_BORDER_MODE = 2'd0,
		REG_WINDOW_SIZE = 2'd1,
		REG_FRAME_ROWS  = 2'd2,
		REG_FRAME_COLS  = 2'd3
	} bfbm_reg_t;

	typedef struct packed {
		logic [1:0]       border_mode;
		logic [4:0]       window_size;
		logic [DIM_W-1:0] frame_rows;
		logic [DIM_W-1:0] frame_cols;
	} bfbm_cfg_t;

	typedef struct packed {
		logic load;
		logic start_read;
		logic win_start;
		logic win_step;
		logic mean_start;
		logic result_load;
	} bfbm_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic win_last;
		logic err;
		logic out_free;
	} bfbm_sts_t;
endpackage

@@ rtl/bfbm_if.sv @@
// ----------------------------------------------------------------------------
// bfbm_if
// request and result channels of the box mean filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface bfbm_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] pixel_in;
	modport source(output valid, req_type, pixel_in, input ready);
	modport sink(input valid, req_type, pixel_in, output ready);
endinterface

interface bfbm_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] mean_value;
	logic        last_pixel;
	logic        config_error;
	modport source(output valid, mean_value, last_pixel, config_error, input ready);
	modport sink(input valid, mean_value, last_pixel, config_error, output ready);
endinterface

@@ rtl/bfbm_ctrl.sv @@
// ----------------------------------------------------------------------------
// bfbm_ctrl
// sequencer: load, position divide, window sweep, mean divide, result; a config error skips to result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "box_filter_boundary_modes_defines.svh"
module bfbm_ctrl
	import bfbm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_type,
	output logic       req_ready,
	input  bfbm_sts_t  sts,
	output bfbm_cmd_t  cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_POS, S_WIN, S_DRAIN, S_MEAN, S_MDIV, S_RESULT
	} state_t;

	state_t state_q;

	always_comb begin
		cmd = '0;
		req_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				cmd.load       = req_valid && !req_type;
				cmd.start_read = req_valid && req_type;
			end
			S_POS:    cmd.win_start   = !sts.div_busy && !sts.err;
			S_WIN:    cmd.win_step    = 1'b1;
			S_MEAN:   cmd.mean_start  = 1'b1;
			S_RESULT: cmd.result_load = sts.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:   if (cmd.start_read) state_q <= S_POS;
				S_POS: begin
					if (!sts.div_busy) state_q <= sts.err ? S_RESULT : S_WIN;
				end
				S_WIN:    if (sts.win_last) state_q <= S_DRAIN;
				S_DRAIN:  state_q <= S_MEAN;
				S_MEAN:   state_q <= S_MDIV;
				S_MDIV:   if (!sts.div_busy) state_q <= S_RESULT;
				S_RESULT: if (sts.out_free) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	`BFBM_ASSERT_IMPL(a_result_slot_free, cmd.result_load, sts.out_free, "result overwrite")
	`BFBM_ASSERT_NEVER(a_step_while_div, cmd.win_step && sts.div_busy, "sweep during divide")
	`BFBM_ASSERT_IMPL(a_ready_only_idle, req_ready, !sts.div_busy, "ready while dividing")
endmodule

@@ rtl/bfbm_datapath.sv @@
// ----------------------------------------------------------------------------
// bfbm_datapath
// frame memory, border mapping, window accumulator, serial divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "box_filter_boundary_modes_defines.svh"
module bfbm_datapath
	import bfbm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  bfbm_cfg_t   cfg,
	input  logic [7:0]  pixel_in,
	input  bfbm_cmd_t   cmd,
	output bfbm_sts_t   sts,
	input  logic        res_ready,
	output logic        res_valid,
	output logic [15:0] mean_value,
	output logic        last_pixel,
	output logic        config_error
);
	typedef struct packed {
		logic             skip;
		logic [IDX_W-1:0] idx;
	} map_t;

	function automatic map_t map_coord(logic signed [9:0] v, logic [DIM_W-1:0] n,
		logic [1:0] mode);
		logic signed [10:0] vv;
		logic signed [10:0] nn;
		logic signed [10:0] m;
		map_t r;
		vv = 11'(v);
		nn = $signed({2'b00, n});
		m = vv;
		r.skip = 1'b0;
		if (vv < 11'sd0 || vv >= nn) begin
			case (bfbm_mode_t'(mode))
				BM_SYMMETRIC: m = (vv < 11'sd0) ? (-vv - 11'sd1) : (nn + nn - vv - 11'sd1);
				BM_REPLICATE: m = (vv < 11'sd0) ? 11'sd0 : (nn - 11'sd1);
				BM_CIRCULAR:  m = (vv < 11'sd0) ? (vv + nn) : (vv - nn);
				BM_ZERO_PAD:  r.skip = 1'b1;
				default:      r.skip = 1'b1;
			endcase
		end
		if (m < 11'sd0) m = 11'sd0;
		if (m > nn - 11'sd1) m = nn - 11'sd1;
		r.idx = m[IDX_W-1:0];
		return r;
	endfunction

	logic [7:0]           frame_mem [MAX_ROWS*MAX_COLS];
	logic [POS_W-1:0]     load_pos_q, read_pos_q;
	logic [DIM_W-1:0]     rows, cols, min_dim;
	logic [POS_W:0]       total;
	logic [POS_W-1:0]     ld_addr, rd_pos;
	logic [POS_W:0]       ld_inc, rd_inc;
	logic                 err_now, err_q, last_q;
	logic [3:0]           half;
	logic signed [5:0]    half_s, dr_q, dc_q;
	logic [IDX_W-1:0]     row_q, col_q;
	logic signed [9:0]    rr, cc;
	map_t                 mr, mc;
	logic [POS_W:0]       win_addr;
	logic [7:0]           rdata_s1;
	logic                 valid_s1;
	logic [SUM_W-1:0]     sum_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DVD_W-1:0]     dvd_q;
	logic [CNT_W-1:0]     den_q, rem_q;
	logic [CNT_W:0]       rem_sh;
	logic                 div_busy_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [CNT_W-1:0]     mean_den;
	logic                 res_valid_q;
	logic [15:0]          mean_q;
	logic                 last_out_q, err_out_q;

	always_comb begin
		rows = (cfg.frame_rows < 9'd2) ? 9'd2 :
			(cfg.frame_rows > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : cfg.frame_rows;
		cols = (cfg.frame_cols < 9'd2) ? 9'd2 :
			(cfg.frame_cols > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cfg.frame_cols;
		total = 17'(rows) * 17'(cols);
		min_dim = (rows < cols) ? rows : cols;
		err_now = !cfg.window_size[0] || ({4'b0, cfg.window_size} > DIM_W'(MAX_WINDOW)) ||
			({4'b0, cfg.window_size} >= min_dim);
		ld_addr = ({1'b0, load_pos_q} >= total) ? '0 : load_pos_q;
		ld_inc = {1'b0, ld_addr} + 17'd1;
		rd_pos = ({1'b0, read_pos_q} >= total) ? '0 : read_pos_q;
		rd_inc = {1'b0, rd_pos} + 17'd1;
		half = cfg.window_size[4:1];
		half_s = $signed({2'b00, half});
		rr = $signed({2'b00, row_q}) + 10'(dr_q);
		cc = $signed({2'b00, col_q}) + 10'(dc_q);
		mr = map_coord(rr, rows, cfg.border_mode);
		mc = map_coord(cc, cols, cfg.border_mode);
		win_addr = 17'(mr.idx) * 17'(cols) + 17'(mc.idx);
		mean_den = (cfg.border_mode == BM_ZERO_PAD) ? cnt_q :
			CNT_W'(cfg.window_size * cfg.window_size);
		rem_sh = {rem_q, dvd_q[DVD_W-1]};
	end

	// frame memory
	always_ff @(posedge clk) begin
		if (cmd.load) frame_mem[ld_addr] <= pixel_in;
		if (cmd.win_step) rdata_s1 <= frame_mem[win_addr[POS_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q <= '0;
			read_pos_q <= '0;
			valid_s1   <= 1'b0;
			div_busy_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.load) load_pos_q <= (ld_inc >= total) ? '0 : ld_inc[POS_W-1:0];
			if (cmd.start_read) read_pos_q <= (rd_inc >= total) ? '0 : rd_inc[POS_W-1:0];
			valid_s1 <= cmd.win_step && !mr.skip && !mc.skip;
			if (cmd.start_read || cmd.mean_start) begin
				div_busy_q <= 1'b1;
			end else if (div_busy_q && div_cnt_q == '0) begin
				div_busy_q <= 1'b0;
			end
			if (cmd.result_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_read) begin
			last_q <= (rd_inc == total);
			err_q  <= err_now;
		end
		// restoring divider, one quotient bit per cycle
		if (cmd.start_read || cmd.mean_start) begin
			dvd_q     <= cmd.start_read ? DVD_W'(rd_pos) : {sum_q, 8'b0};
			den_q     <= cmd.start_read ? CNT_W'(cols) : mean_den;
			rem_q     <= '0;
			div_cnt_q <= DIV_CNT_W'(DVD_W - 1);
		end else if (div_busy_q) begin
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q <= CNT_W'(rem_sh - {1'b0, den_q});
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[CNT_W-1:0];
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			end
			div_cnt_q <= div_cnt_q - 1'b1;
		end
		if (cmd.win_start) begin
			row_q <= dvd_q[IDX_W-1:0];
			col_q <= rem_q[IDX_W-1:0];
			dr_q  <= -half_s;
			dc_q  <= -half_s;
			sum_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.win_step) begin
				if (dc_q == half_s) begin
					dc_q <= -half_s;
					dr_q <= dr_q + 6'sd1;
				end else begin
					dc_q <= dc_q + 6'sd1;
				end
			end
			if (valid_s1) begin
				sum_q <= sum_q + SUM_W'(rdata_s1);
				cnt_q <= cnt_q + 1'b1;
			end
		end
		if (cmd.result_load) begin
			mean_q     <= err_q ? 16'd0 : dvd_q[15:0];
			last_out_q <= last_q;
			err_out_q  <= err_q;
		end
	end

	assign sts.div_busy = div_busy_q;
	assign sts.win_last = (dr_q == half_s) && (dc_q == half_s);
	assign sts.err      = err_q;
	assign sts.out_free = !res_valid_q || res_ready;
	assign res_valid    = res_valid_q;
	assign mean_value   = mean_q;
	assign last_pixel   = last_out_q;
	assign config_error = err_out_q;

	`BFBM_ASSERT_NEVER(a_load_and_read, cmd.load && cmd.start_read, "load and read together")
	`BFBM_ASSERT_IMPL(a_div_start_idle, cmd.mean_start, !div_busy_q, "divider restarted")
	`BFBM_ASSERT_IMPL(a_result_no_div, cmd.result_load, !div_busy_q, "result before divide")
endmodule

@@ rtl/box_filter_boundary_modes.sv @@
// ----------------------------------------------------------------------------
// box_filter_boundary_modes
// box mean filter over one stored image plane with selectable border modes
// ----------------------------------------------------------------------------
// channel  dir  payload                                  handshake
// req      in   req_type, pixel_in                       valid / ready
// res      out  mean_value, last_pixel, config_error     valid / ready
// apb      in   border_mode, window_size, frame_rows/cols psel/penable/pwrite
//
// a load is one memory write
// a read runs a serial divide for the position and, with a valid config, one
// frame memory read per window pixel and a serial mean divide
// one request at a time; the result register frees the input while res stalls
// no clearing pass after reset, the frame memory is undefined until loaded
`timescale 1ns / 1ps
module box_filter_boundary_modes
	import bfbm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	bfbm_req_if.sink    req,
	bfbm_res_if.source  res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	bfbm_cfg_t cfg_q;
	bfbm_cmd_t cmd;
	bfbm_sts_t sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.border_mode <= 2'd0;
			cfg_q.window_size <= 5'd3;
			cfg_q.frame_rows  <= 9'd256;
			cfg_q.frame_cols  <= 9'd256;
		end else if (psel && penable && pwrite) begin
			case (bfbm_reg_t'(paddr[3:2]))
				REG_BORDER_MODE: cfg_q.border_mode <= pwdata[1:0];
				REG_WINDOW_SIZE: cfg_q.window_size <= pwdata[4:0];
				REG_FRAME_ROWS:  cfg_q.frame_rows  <= pwdata[8:0];
				REG_FRAME_COLS:  cfg_q.frame_cols  <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (bfbm_reg_t'(paddr[3:2]))
			REG_BORDER_MODE: prdata = {30'b0, cfg_q.border_mode};
			REG_WINDOW_SIZE: prdata = {27'b0, cfg_q.window_size};
			REG_FRAME_ROWS:  prdata = {23'b0, cfg_q.frame_rows};
			REG_FRAME_COLS:  prdata = {23'b0, cfg_q.frame_cols};
			default:         prdata = '0;
		endcase
	end

	bfbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bfbm_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.pixel_in     (req.pixel_in),
		.cmd          (cmd),
		.sts          (sts),
		.res_ready    (res.ready),
		.res_valid    (res.valid),
		.mean_value   (res.mean_value),
		.last_pixel   (res.last_pixel),
		.config_error (res.config_error)
	);
endmodule
